// ----- hw/rtl/pcx_rle_planar_to_nibble_decoder_core_macros.svh -----
// Assertion macros shared by the decoder checker.
// No dependencies; include once per file that asserts.
`ifndef PCX_RLE_PLANAR_TO_NIBBLE_DECODER_CORE_MACROS_SVH
`define PCX_RLE_PLANAR_TO_NIBBLE_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PCX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PCX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pcx_rle_pkg.sv -----
// Shared types and constants for the PCX planar RLE to nibble decoder.
// No dependencies.
`default_nettype none

package pcx_rle_pkg;

    localparam int LINE_STORE_BYTES = 128;
    localparam int MAX_GROUPS       = 32;
    localparam int BPL_CAP          = (LINE_STORE_BYTES / 4 > MAX_GROUPS) ?
                                      MAX_GROUPS : LINE_STORE_BYTES / 4;
    localparam int ADDR_W           = $clog2(LINE_STORE_BYTES);
    localparam int WP_W             = ADDR_W + 1;

    localparam int BPL_W   = 6;
    localparam int WIDTH_W = 8;
    localparam int ROWS_W  = 10;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 2;

    localparam logic [7:0] RUN_MARK = 8'hC0;

    localparam logic [IDX_W-1:0] CFG_BPL   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_WIDTH = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ROWS  = 2'd2;

    localparam logic [2:0] VB_HALF = 3'd2;
    localparam logic [2:0] VB_FULL = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_PUSH
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/pcx_rle_planar_to_nibble_decoder_core.sv -----
// A literal is stored in its accept cycle; a run's data byte is stored in its accept cycle and
// its further copies are written while input is stalled. A line-completing beat starts emission:
// per group, 4 line-store reads then a push, which waits while the output is stalled.
// Throughput is set by the single-port line store: one byte written or read per cycle.
// Reset (i_rst_n low, synchronous) clears control and counters and sets config to BPL 1,
// width 1, rows 0; the line store is not cleared, it is always written before it is read.
`default_nettype none

module pcx_rle_planar_to_nibble_decoder_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pcx_rle_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [pcx_rle_pkg::CFG_W-1:0]     i_cfg_data,
    // compressed input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [7:0]                        i_code_byte,
    input  wire logic                              i_first_of_image,
    // pixel output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [7:0]                             o_pixel_pair_0,
    output logic [7:0]                             o_pixel_pair_1,
    output logic [7:0]                             o_pixel_pair_2,
    output logic [7:0]                             o_pixel_pair_3,
    output logic [2:0]                             o_valid_bytes,
    output logic                                   o_last_in_row,
    output logic                                   o_last_in_image
);
    import pcx_rle_pkg::*;

    function automatic logic [7:0] pack_pair(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] a,
                                             input logic [1:0] k);
        logic [2:0] hi;
        logic [2:0] lo;
        hi = 3'd7 - {k, 1'b0};
        lo = 3'd6 - {k, 1'b0};
        return {a[lo], b[lo], g[lo], r[lo], a[hi], b[hi], g[hi], r[hi]};
    endfunction

    // config
    logic [BPL_W-1:0]   r_bpl;
    logic [WIDTH_W-1:0] r_width;
    logic [ROWS_W-1:0]  r_rows;

    // control
    t_state             r_state, n_state;
    logic [WP_W-1:0]    r_wp, n_wp;
    logic               r_await, n_await;
    logic [5:0]         r_pend, n_pend;
    logic [ROWS_W-1:0]  r_rows_done, n_rows_done;
    logic [5:0]         r_count, n_count;
    logic [7:0]         r_code, n_code;
    logic [4:0]         r_group, n_group;
    logic [1:0]         r_phase, n_phase;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_out_valid, n_out_valid;

    // payload
    logic [7:0]         r_plane [3];
    logic [7:0]         r_rd_data;
    logic [7:0]         r_pp0, r_pp1, r_pp2, r_pp3;
    logic [2:0]         r_vb;
    logic               r_lrow, r_limg;

    logic [7:0]         line_store [LINE_STORE_BYTES];

    // derived geometry
    logic [BPL_W-1:0]   eff_bpl;
    logic [7:0]         line_len;
    logic [7:0]         eff_width;
    logic [5:0]         groups;

    always_comb begin
        if (r_bpl == '0) begin
            eff_bpl = BPL_W'(1);
        end else if (r_bpl > BPL_W'(BPL_CAP)) begin
            eff_bpl = BPL_W'(BPL_CAP);
        end else begin
            eff_bpl = r_bpl;
        end
        line_len = {eff_bpl, 2'b00};
        if (r_width == '0) begin
            eff_width = 8'd1;
        end else if (r_width > line_len) begin
            eff_width = line_len;
        end else begin
            eff_width = r_width;
        end
        groups = 6'((9'(eff_width) + 9'd3) >> 2);
    end

    // step decode
    logic               accept;
    logic               base_await;
    logic [5:0]         base_pend;
    logic [WP_W-1:0]    base_wp;
    logic [ROWS_W-1:0]  base_rows;
    logic               ignore;
    logic               is_run_head;
    logic               idle_write;
    logic               wr_en;
    logic [5:0]         count_cur;
    logic [WP_W-1:0]    wp_cur;
    logic [WP_W-1:0]    wp_inc;
    logic [7:0]         code_cur;
    logic               line_done;
    logic               more;
    logic               rd_en;
    logic               out_free;
    logic               last_group;
    logic               last_image;
    logic               half_group;

    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign base_await  = i_first_of_image ? 1'b0 : r_await;
    assign base_pend   = i_first_of_image ? '0 : r_pend;
    assign base_wp     = i_first_of_image ? '0 : r_wp;
    assign base_rows   = i_first_of_image ? '0 : r_rows_done;
    assign ignore      = base_rows >= r_rows;
    assign is_run_head = i_code_byte > RUN_MARK;
    assign idle_write  = accept && !ignore &&
                         (base_await ? (base_pend != '0) : !is_run_head);

    assign count_cur = (r_state == ST_IDLE) ? (base_await ? base_pend : 6'd1) : r_count;
    assign wp_cur    = (r_state == ST_IDLE) ? base_wp : r_wp;
    assign code_cur  = (r_state == ST_IDLE) ? i_code_byte : r_code;
    assign wp_inc    = wp_cur + WP_W'(1);
    assign line_done = wp_inc >= WP_W'(line_len);
    assign more      = (count_cur > 6'd1) && !line_done;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_group = (6'(r_group) + 6'd1) == groups;
    assign last_image = (11'(r_rows_done) + 11'd1) == 11'(r_rows);
    assign half_group = eff_width < ({1'b0, r_group, 2'b00} + 8'd4);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_WRITE: begin
                if (wr_en) begin
                    if (line_done) begin
                        n_state = ST_READ;
                    end else if (more) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                if (r_phase == 2'd3) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_state = last_group ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                wr_en      = idle_write;
            end
            ST_WRITE: wr_en = 1'b1;
            ST_READ:  rd_en = 1'b1;
            ST_PUSH:  ;
            default:  ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_wp        = r_wp;
        n_await     = r_await;
        n_pend      = r_pend;
        n_rows_done = r_rows_done;
        n_count     = r_count;
        n_code      = r_code;
        n_group     = r_group;
        n_phase     = r_phase;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && i_out_stall;

        if (accept) begin
            n_wp        = base_wp;
            n_rows_done = base_rows;
            n_await     = base_await;
            n_pend      = base_pend;
            if (!ignore) begin
                if (base_await) begin
                    n_await = 1'b0;
                    n_pend  = '0;
                end else if (is_run_head) begin
                    n_await = 1'b1;
                    n_pend  = 6'(i_code_byte - RUN_MARK);
                end
            end
        end

        if (wr_en) begin
            n_wp    = wp_inc;
            n_count = count_cur - 6'd1;
            n_code  = code_cur;
            if (line_done) begin
                n_group = '0;
                n_phase = '0;
                n_addr  = '0;
            end
        end

        if (r_state == ST_READ) begin
            n_phase = r_phase + 2'd1;
            n_addr  = (r_phase == 2'd3) ? ADDR_W'(r_group) + ADDR_W'(1)
                                        : r_addr + ADDR_W'(eff_bpl);
        end

        if (r_state == ST_PUSH && out_free) begin
            n_out_valid = 1'b1;
            if (last_group) begin
                n_wp        = '0;
                n_rows_done = r_rows_done + ROWS_W'(1);
            end else begin
                n_group = r_group + 5'd1;
                n_phase = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_await     <= 1'b0;
            r_pend      <= '0;
            r_rows_done <= '0;
            r_count     <= '0;
            r_group     <= '0;
            r_phase     <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_bpl       <= BPL_W'(1);
            r_width     <= WIDTH_W'(1);
            r_rows      <= '0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_await     <= n_await;
            r_pend      <= n_pend;
            r_rows_done <= n_rows_done;
            r_count     <= n_count;
            r_group     <= n_group;
            r_phase     <= n_phase;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BPL:   r_bpl   <= i_cfg_data[BPL_W-1:0];
                    CFG_WIDTH: r_width <= i_cfg_data[WIDTH_W-1:0];
                    CFG_ROWS:  r_rows  <= i_cfg_data[ROWS_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    // line store: one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            line_store[wp_cur[ADDR_W-1:0]] <= code_cur;
        end
        if (rd_en) begin
            r_rd_data <= line_store[r_addr];
        end
    end

    // plane bytes land in the cycle after their read; plane 3 stays in r_rd_data
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            case (r_phase)
                2'd1:    r_plane[0] <= r_rd_data;
                2'd2:    r_plane[1] <= r_rd_data;
                2'd3:    r_plane[2] <= r_rd_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUSH && out_free) begin
            r_pp0  <= pack_pair(r_plane[0], r_plane[1], r_plane[2], r_rd_data, 2'd0);
            r_pp1  <= pack_pair(r_plane[0], r_plane[1], r_plane[2], r_rd_data, 2'd1);
            r_pp2  <= half_group ? 8'd0 :
                      pack_pair(r_plane[0], r_plane[1], r_plane[2], r_rd_data, 2'd2);
            r_pp3  <= half_group ? 8'd0 :
                      pack_pair(r_plane[0], r_plane[1], r_plane[2], r_rd_data, 2'd3);
            r_vb   <= half_group ? VB_HALF : VB_FULL;
            r_lrow <= last_group;
            r_limg <= last_group && last_image;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_pixel_pair_0  = r_pp0;
    assign o_pixel_pair_1  = r_pp1;
    assign o_pixel_pair_2  = r_pp2;
    assign o_pixel_pair_3  = r_pp3;
    assign o_valid_bytes   = r_vb;
    assign o_last_in_row   = r_lrow;
    assign o_last_in_image = r_limg;

endmodule

`default_nettype wire

// ----- hw/rtl/pcx_rle_chk.sv -----
// Port-level checker for the PCX planar RLE decoder, bound to the top level.
// Depends on pcx_rle_pkg and the decoder assertion macro header.
`default_nettype none
`include "pcx_rle_planar_to_nibble_decoder_core_macros.svh"

module pcx_rle_chk (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic [7:0]                        o_pixel_pair_0,
    input  wire logic [7:0]                        o_pixel_pair_1,
    input  wire logic [7:0]                        o_pixel_pair_2,
    input  wire logic [7:0]                        o_pixel_pair_3,
    input  wire logic [2:0]                        o_valid_bytes,
    input  wire logic                              o_last_in_row,
    input  wire logic                              o_last_in_image
);
    import pcx_rle_pkg::*;

    // only a half group or a full group is ever produced
    `PCX_ASSERT_NOW(a_vb_code, i_clk, i_rst_n, o_out_valid, (o_valid_bytes == VB_HALF) || (o_valid_bytes == VB_FULL), "valid_bytes not 2 or 4")

    // a half group is always the row's tail, with its upper bytes zeroed
    `PCX_ASSERT_NOW(a_half_tail, i_clk, i_rst_n, o_out_valid && (o_valid_bytes == VB_HALF), o_last_in_row && (o_pixel_pair_2 == 8'd0) && (o_pixel_pair_3 == 8'd0), "half group not a clean row tail")

    // end of image only on the end of a row
    `PCX_ASSERT_NOW(a_img_row, i_clk, i_rst_n, o_out_valid && o_last_in_image, o_last_in_row, "last_in_image without last_in_row")

    // a stalled result beat holds
    `PCX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_pixel_pair_0) && $stable(o_pixel_pair_1) && $stable(o_valid_bytes) && $stable(o_last_in_row), "stalled result beat changed")

endmodule

bind pcx_rle_planar_to_nibble_decoder_core pcx_rle_chk u_pcx_rle_chk (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pcx_rle_planar_to_nibble_decoder_core: drives code bytes and
// register writes, predicts the packed pixel beats and checks each one as it leaves.
// Depends on pcx_rle_pkg and the core RTL.

module tb_top;
    import pcx_rle_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 100;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 66;
    // index 3 maps to no register; writes there must change nothing
    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] code;
        logic       first;
    } t_code_item;

    typedef struct packed {
        logic [3:0][7:0] pairs;
        logic [2:0]      nbytes;
        logic            row_end;
        logic            image_end;
    } t_pixel_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_code_byte = '0;
    logic               i_first_of_image = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [7:0]         o_pixel_pair_0;
    logic [7:0]         o_pixel_pair_1;
    logic [7:0]         o_pixel_pair_2;
    logic [7:0]         o_pixel_pair_3;
    logic [2:0]         o_valid_bytes;
    logic               o_last_in_row;
    logic               o_last_in_image;

    pcx_rle_planar_to_nibble_decoder_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_code_byte      (i_code_byte),
        .i_first_of_image (i_first_of_image),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pixel_pair_0   (o_pixel_pair_0),
        .o_pixel_pair_1   (o_pixel_pair_1),
        .o_pixel_pair_2   (o_pixel_pair_2),
        .o_pixel_pair_3   (o_pixel_pair_3),
        .o_valid_bytes    (o_valid_bytes),
        .o_last_in_row    (o_last_in_row),
        .o_last_in_image  (o_last_in_image)
    );

    t_code_item  pending_codes[$];
    t_pixel_beat expected_pixels[$];
    t_code_item  next_code;
    t_pixel_beat got_beat;
    t_pixel_beat want_beat;
    int          pair_idx;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          in_beat = 1'b0;

    // decoder shadow state and register copies
    logic [7:0]         line_copy [LINE_STORE_BYTES];
    int                 fill_pos = 0;
    bit                 run_pending = 1'b0;
    logic [5:0]         run_count = '0;
    logic [ROWS_W-1:0]  rows_out = '0;
    logic [BPL_W-1:0]   bpl_reg = 6'd1;
    logic [WIDTH_W-1:0] width_reg = 8'd1;
    logic [ROWS_W-1:0]  rows_reg = '0;

    function automatic int plane_bytes();
        int b;
        b = bpl_reg;
        if (b < 1) b = 1;
        if (b > BPL_CAP) b = BPL_CAP;
        return b;
    endfunction

    task automatic decode_code_byte(input logic [7:0] code, input logic first);
        int          line_len, copies, bpl, width, groups, left, gi, k;
        logic [7:0]  run_span;
        logic [7:0]  r, g, b, a;
        t_pixel_beat beat;
        if (first) begin
            rows_out    = '0;
            fill_pos    = 0;
            run_pending = 1'b0;
            run_count   = '0;
        end
        if (rows_out >= rows_reg) return;
        bpl      = plane_bytes();
        line_len = 4 * bpl;
        if (run_pending) begin
            copies      = run_count;
            run_pending = 1'b0;
            run_count   = '0;
        end else if (code > RUN_MARK) begin
            run_span    = code - RUN_MARK;
            run_count   = run_span[5:0];
            run_pending = 1'b1;
            return;
        end else begin
            copies = 1;
        end
        if (copies == 0) return;
        // run copies past the end of the line are dropped
        do begin
            if (fill_pos < LINE_STORE_BYTES) line_copy[fill_pos] = code;
            fill_pos++;
            copies--;
        end while (copies > 0 && fill_pos < line_len);
        if (fill_pos < line_len) return;

        width = width_reg;
        if (width < 1) width = 1;
        if (width > line_len) width = line_len;
        groups = (width + 3) / 4;
        for (gi = 0; gi < groups; gi++) begin
            r = line_copy[gi];
            g = line_copy[bpl + gi];
            b = line_copy[2 * bpl + gi];
            a = line_copy[3 * bpl + gi];
            left = width - 4 * gi;
            beat.nbytes = (left < 4) ? VB_HALF : VB_FULL;
            // earlier pixel (higher plane bit) lands in the low nibble
            for (k = 0; k < 4; k++)
                beat.pairs[k] = (k < beat.nbytes) ?
                    {a[6-2*k], b[6-2*k], g[6-2*k], r[6-2*k],
                     a[7-2*k], b[7-2*k], g[7-2*k], r[7-2*k]} : 8'h00;
            beat.row_end   = (gi + 1 == groups);
            beat.image_end = beat.row_end && (rows_out + 1 == rows_reg);
            expected_pixels.push_back(beat);
        end
        rows_out = rows_out + 1'b1;
        fill_pos = 0;
    endtask

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // accept side: check pixel beats, track register writes, predict on code beats
    always @(posedge i_clk) begin
        in_beat = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got_beat.pairs     = {o_pixel_pair_3, o_pixel_pair_2,
                                      o_pixel_pair_1, o_pixel_pair_0};
                got_beat.nbytes    = o_valid_bytes;
                got_beat.row_end   = o_last_in_row;
                got_beat.image_end = o_last_in_image;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel beat, got %h", $time, got_beat);
                    mismatches++;
                end else begin
                    want_beat = expected_pixels.pop_front();
                    for (pair_idx = 0; pair_idx < 4; pair_idx++)
                        if (got_beat.pairs[pair_idx] !== want_beat.pairs[pair_idx]) begin
                            $display("%0t: pixel_pair_%0d expected %h, got %h", $time,
                                     pair_idx, want_beat.pairs[pair_idx],
                                     got_beat.pairs[pair_idx]);
                            mismatches++;
                        end
                    if (got_beat.nbytes !== want_beat.nbytes) begin
                        $display("%0t: valid_bytes expected %0d, got %0d", $time,
                                 want_beat.nbytes, got_beat.nbytes);
                        mismatches++;
                    end
                    if (got_beat.row_end !== want_beat.row_end) begin
                        $display("%0t: last_in_row expected %b, got %b", $time,
                                 want_beat.row_end, got_beat.row_end);
                        mismatches++;
                    end
                    if (got_beat.image_end !== want_beat.image_end) begin
                        $display("%0t: last_in_image expected %b, got %b", $time,
                                 want_beat.image_end, got_beat.image_end);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BPL:   bpl_reg   = i_cfg_data[BPL_W-1:0];
                    CFG_WIDTH: width_reg = i_cfg_data[WIDTH_W-1:0];
                    CFG_ROWS:  rows_reg  = i_cfg_data[ROWS_W-1:0];
                    default: ;
                endcase
            end
            if (in_beat) decode_code_byte(i_code_byte, i_first_of_image);
        end
    end

    // code byte driver: hold a stalled beat, otherwise maybe launch the next one
    always @(negedge i_clk) begin
        if (!i_in_valid || in_beat) begin
            if (pending_codes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_code = pending_codes.pop_front();
                i_in_valid       <= 1'b1;
                i_code_byte      <= next_code.code;
                i_first_of_image <= next_code.first;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void push_code(input int code, input bit first);
        t_code_item item;
        item.code  = code[7:0];
        item.first = first;
        pending_codes.push_back(item);
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every beat to be sent and every pixel beat to arrive, then let runs finish
    task automatic settle();
        @(posedge i_clk);
        while (pending_codes.size() != 0 || i_in_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // well-formed images with random literals and runs, plus some stray bytes
    task automatic queue_random_stream(input int budget);
        int queued, need, len, row, line_len;
        bit first;
        queued   = 0;
        first    = 1'b1;
        row      = 0;
        line_len = 4 * plane_bytes();
        need     = line_len;
        while (queued < budget) begin
            if ($urandom_range(0, 19) == 0) begin
                push_code($urandom_range(0, 255), $urandom_range(0, 7) == 0);
                queued++;
            end else if ($urandom_range(0, 3) == 0) begin
                len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 63) :
                      $urandom_range(1, (need < 63) ? need : 63);
                push_code(RUN_MARK + len, first);
                push_code($urandom_range(0, 255), 1'b0);
                first  = 1'b0;
                need  -= len;
                queued += 2;
            end else begin
                push_code($urandom_range(0, RUN_MARK), first);
                first = 1'b0;
                need--;
                queued++;
            end
            if (need <= 0) begin
                need = line_len;
                row++;
                if (row >= rows_reg) begin
                    row   = 0;
                    first = 1'b1;
                end
            end
        end
    endtask

    initial begin
        int phase, pick, bpl, width;
        send_idle_pct = 9;
        stall_pct     = 66;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: zero rows, so everything is ignored
        push_code(8'h3C, 1'b1);
        settle();

        // one plane byte per line, three rows
        write_reg(CFG_BPL, 1);
        write_reg(CFG_WIDTH, 4);
        write_reg(CFG_ROWS, 3);
        push_code(8'hC0, 1'b1);
        push_code(8'h00, 1'b0);
        push_code(8'hAA, 1'b0);
        push_code(8'h55, 1'b0);
        push_code(8'hFF, 1'b0);     // 63 copies, all but four dropped
        push_code(8'hFF, 1'b0);
        push_code(8'hC1, 1'b0);
        push_code(8'h81, 1'b0);
        push_code(8'hC2, 1'b0);
        push_code(8'h3C, 1'b0);
        push_code(8'hC0, 1'b0);
        push_code(8'hE0, 1'b0);     // image done, ignored
        push_code(8'hC3, 1'b1);
        push_code(8'h07, 1'b1);     // restart drops the pending run
        settle();

        // zero values act as one; upper data bits are don't-care
        write_reg(CFG_BPL, 10'h3C0);
        write_reg(CFG_WIDTH, 10'h300);
        write_reg(CFG_ROWS, 1023);
        write_reg(CFG_SPARE, 10'h2A5);
        push_code(8'h01, 1'b1);
        push_code(8'h02, 1'b0);
        push_code(8'h04, 1'b0);
        push_code(8'h08, 1'b0);
        settle();

        // oversize values saturate to 32 plane bytes and 128 output bytes
        write_reg(CFG_BPL, 63);
        write_reg(CFG_WIDTH, 255);
        push_code(8'hFF, 1'b1);
        push_code(8'hA5, 1'b0);
        push_code(8'hFF, 1'b0);
        push_code(8'h5A, 1'b0);
        push_code(8'hC2, 1'b0);
        push_code(8'h3C, 1'b0);
        settle();

        // shrink the line under a partly filled store
        write_reg(CFG_BPL, 32);
        write_reg(CFG_WIDTH, 128);
        push_code(8'h11, 1'b1);
        push_code(8'h22, 1'b0);
        push_code(8'h33, 1'b0);
        push_code(8'h44, 1'b0);
        push_code(8'h88, 1'b0);
        settle();
        write_reg(CFG_BPL, 1);
        write_reg(CFG_WIDTH, 3);
        push_code(8'h77, 1'b0);
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase / 2)
                0:       begin send_idle_pct = 9;  stall_pct = 66; end
                1:       begin send_idle_pct = 66; stall_pct = 9;  end
                default: begin send_idle_pct = 0;  stall_pct = 0;  end
            endcase
            pick = $urandom_range(0, 15);
            bpl  = (pick == 0) ? 0 : (pick == 1) ? 32 : (pick == 2) ? 63 :
                   $urandom_range(1, 6);
            write_reg(CFG_BPL, ($urandom_range(0, 15) << BPL_W) | bpl);
            pick  = $urandom_range(0, 15);
            width = (pick == 0) ? 0 : (pick == 1) ? 255 : (pick == 2) ? 4 * plane_bytes() :
                    $urandom_range(1, 4 * plane_bytes());
            write_reg(CFG_WIDTH, ($urandom_range(0, 3) << WIDTH_W) | width);
            write_reg(CFG_ROWS, ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(1, 5));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom_range(0, 1023));
            queue_random_stream(PHASE_ITEMS);
            settle();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
